/* rtl/start_key_frame_receiver_with_sum_check_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame receiver.
// ----------------------------------------------------------------------------
`ifndef START_KEY_FRAME_RECEIVER_WITH_SUM_CHECK_DEFINES_SVH
`define START_KEY_FRAME_RECEIVER_WITH_SUM_CHECK_DEFINES_SVH

// same-cycle implication
`define SKFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// next-cycle implication
`define SKFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

/* rtl/skfr_pkg.sv */
// ----------------------------------------------------------------------------
// Frame receiver package
// Frame length, counter width, reset key and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package skfr_pkg;

  localparam int FRAME_LEN = 16;
  localparam int CNT_W = $clog2(FRAME_LEN + 1);
  localparam logic [7:0] START_KEY_RESET = 8'h55;

  typedef struct packed {
    logic       receiving;
    logic [4:0] position;
    logic       byte_stored;
    logic       frame_done;
    logic       checksum_ok;
  } result_t;

endpackage

`default_nettype wire

/* rtl/start_key_frame_receiver_with_sum_check.sv */
// ----------------------------------------------------------------------------
// Start key frame receiver with sum check
// Frames a byte stream on a start key and checks a 16-bit additive trailer.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  cfg      cfg_valid/cfg_ready   cfg_data (start key)
//  in       in_valid/in_ready     rx_byte
//  out      out_valid/out_ready   receiving, position, byte_stored,
//                                 frame_done, checksum_ok
//
//  One word per cycle while in_ready is high; each result appears in the cycle after its input word.
//  Each result is held in the single result register after the frame logic.
//  cfg_ready is always high; the start key applies from the next cycle.
//  Synchronous reset returns to idle with start key 0x55.
//  A stalled output blocks input only while the result register is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "start_key_frame_receiver_with_sum_check_defines.svh"

module start_key_frame_receiver_with_sum_check (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            receiving,
  output logic [4:0]      position,
  output logic            byte_stored,
  output logic            frame_done,
  output logic            checksum_ok
);
  import skfr_pkg::*;

  result_t core_result;
  result_t out_result;
  logic    accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  skfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .result    (core_result)
  );

  skfr_out u_out (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .result_in  (core_result),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_out (out_result)
  );

  assign receiving   = out_result.receiving;
  assign position    = out_result.position;
  assign byte_stored = out_result.byte_stored;
  assign frame_done  = out_result.frame_done;
  assign checksum_ok = out_result.checksum_ok;

  `SKFR_ASSERT_NOW(a_done_closes, out_valid && frame_done, byte_stored && !receiving)
  `SKFR_ASSERT_NOW(a_open_clears, out_valid && receiving && !byte_stored, position == 5'd0)
  `SKFR_ASSERT_NOW(a_stall_only_full, !in_ready, out_valid && !out_ready)
  `SKFR_ASSERT_NEXT(a_accept_fills, accept, out_valid)

endmodule

`default_nettype wire

/* rtl/skfr_core.sv */
// ----------------------------------------------------------------------------
// Frame receiver core
// Start key detect, byte counter, running sum and trailer compare.
// ----------------------------------------------------------------------------
`default_nettype none

module skfr_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              accept,
  input  wire logic [7:0]        rx_byte,
  output skfr_pkg::result_t      result
);
  import skfr_pkg::*;

  logic [7:0]       start_key;
  logic             in_frame;
  logic [CNT_W-1:0] byte_count;
  logic [15:0]      running_sum;
  logic [7:0]       trailer_high;
  logic             sum_good;

  logic             in_frame_next;
  logic [CNT_W-1:0] byte_count_next;
  logic [15:0]      running_sum_next;
  logic [7:0]       trailer_high_next;
  logic             sum_good_next;
  logic             stored;
  logic             done;
  logic [CNT_W-1:0] count_inc;

  assign count_inc = byte_count + CNT_W'(1);

  always_comb begin
    in_frame_next     = in_frame;
    byte_count_next   = byte_count;
    running_sum_next  = running_sum;
    trailer_high_next = trailer_high;
    sum_good_next     = sum_good;
    stored            = 1'b0;
    done              = 1'b0;
    if (in_frame) begin
      stored          = 1'b1;
      byte_count_next = count_inc;
      if (count_inc <= CNT_W'(FRAME_LEN - 2)) begin
        running_sum_next = running_sum + {8'h00, rx_byte};
      end else if (count_inc == CNT_W'(FRAME_LEN - 1)) begin
        trailer_high_next = rx_byte;
      end else begin
        sum_good_next = (trailer_high == running_sum[15:8]) && (rx_byte == running_sum[7:0]);
        in_frame_next = 1'b0;
        done          = 1'b1;
      end
    end else if (rx_byte == start_key) begin
      in_frame_next    = 1'b1;
      byte_count_next  = '0;
      running_sum_next = '0;
    end
  end

  assign result.receiving   = in_frame_next;
  assign result.position    = 5'(byte_count_next);
  assign result.byte_stored = stored;
  assign result.frame_done  = done;
  assign result.checksum_ok = sum_good_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_key    <= START_KEY_RESET;
      in_frame     <= 1'b0;
      byte_count   <= '0;
      running_sum  <= '0;
      trailer_high <= '0;
      sum_good     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        start_key <= cfg_data;
      end
      if (accept) begin
        in_frame     <= in_frame_next;
        byte_count   <= byte_count_next;
        running_sum  <= running_sum_next;
        trailer_high <= trailer_high_next;
        sum_good     <= sum_good_next;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/skfr_out.sv */
// ----------------------------------------------------------------------------
// Frame receiver result register
// Hold one result word and decouple input acceptance from output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module skfr_out (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire skfr_pkg::result_t result_in,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output skfr_pkg::result_t      result_out
);
  import skfr_pkg::*;

  result_t word;
  logic    word_valid;

  assign in_ready   = !word_valid || out_ready;
  assign out_valid  = word_valid;
  assign result_out = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      word_valid <= 1'b1;
    end else if (out_ready) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word <= result_in;
    end
  end

endmodule

`default_nettype wire
